// ===== rtl/core/fifo_with_running_minimum_top_macros.svh =====
// ----------------------------------------------------------------------------
// fifo_with_running_minimum_top_macros.svh
// Assertion macros shared by the running-minimum FIFO.
// ----------------------------------------------------------------------------
`ifndef FIFO_WITH_RUNNING_MINIMUM_TOP_MACROS_SVH
`define FIFO_WITH_RUNNING_MINIMUM_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define FWRM_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define FWRM_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/fwrm_pkg.sv =====
// ----------------------------------------------------------------------------
// fwrm_pkg
// Types and defaults for the running-minimum FIFO.
// ----------------------------------------------------------------------------
package fwrm_pkg;

    localparam int FWRM_DEPTH       = 64;
    localparam int FWRM_VALUE_WIDTH = 32;

    typedef enum logic [1:0] {
        OP_PUSH  = 2'd0,
        OP_POP   = 2'd1,
        OP_CLEAR = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_POP_EMPTY = 2'd1,
        STATUS_PUSH_FULL = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_REB_RD,
        ST_REB_WR,
        ST_POP_RD,
        ST_POP_FIN,
        ST_FINISH
    } state_t;

endpackage

// ===== rtl/core/fifo_with_running_minimum_top.sv =====
// ----------------------------------------------------------------------------
// fifo_with_running_minimum_top
// Queue of signed values that reports its minimum after every operation.
// ----------------------------------------------------------------------------
// Input channel: in_valid / in_stall carry op (push, pop, clear) and value.
// Output channel: out_valid / out_stall carry popped_value, min_value,
// count and status, exactly one result item per input item.
// The block takes one item at a time; in_stall is high while it works.
// Push, clear, failed ops and the unused code pass from accept through the
// execute and finish states to the result. A pop adds a read and a pop-finish
// state. A pop that finds the checked region empty first rebuilds suffix
// minimums backward over all entries in the queue through the single read
// port of the value memory, with a read state and then a write state per entry.
// These rebuilds are amortized over the following pops.
// The result sits in an output register; the next item is accepted while
// the receiver stalls, and its result waits in the finish state until the
// register frees up.
// Reset empties the queue at once; the memories need no clearing.
// ----------------------------------------------------------------------------
module fifo_with_running_minimum_top #(
    parameter int DEPTH       = fwrm_pkg::FWRM_DEPTH,
    parameter int VALUE_WIDTH = fwrm_pkg::FWRM_VALUE_WIDTH
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [1:0]                    op,
    input  logic signed [VALUE_WIDTH-1:0] value,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [VALUE_WIDTH-1:0] popped_value,
    output logic signed [VALUE_WIDTH-1:0] min_value,
    output logic [$clog2(DEPTH+1)-1:0]    count,
    output logic [1:0]                    status
);
    import fwrm_pkg::*;

    `include "fifo_with_running_minimum_top_macros.svh"

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = CW + 1;
    localparam int VW = VALUE_WIDTH;

    localparam logic [SW-1:0] DEPTH_S   = SW'(DEPTH);
    localparam logic [CW-1:0] DEPTH_C   = CW'(DEPTH);
    localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);

    function automatic logic signed [VW-1:0] smin(input logic signed [VW-1:0] a,
                                                  input logic signed [VW-1:0] b);
        return (a <= b) ? a : b;
    endfunction

    logic signed [VW-1:0] value_mem [DEPTH];
    logic signed [VW-1:0] min_mem   [DEPTH];

    state_t               state_reg, state_next;
    op_t                  op_reg, op_next;
    logic signed [VW-1:0] value_reg, value_next;
    logic [AW-1:0]        head_reg, head_next;
    logic [CW-1:0]        count_reg, count_next;
    logic [AW-1:0]        checked_reg, checked_next;
    logic signed [VW-1:0] front_min_reg, front_min_next;
    logic signed [VW-1:0] back_min_reg, back_min_next;
    logic signed [VW-1:0] run_min_reg, run_min_next;
    logic [AW-1:0]        ridx_reg, ridx_next;
    logic [AW-1:0]        raddr_reg, raddr_next;
    logic                 first_reg, first_next;
    logic signed [VW-1:0] popped_reg, popped_next;
    status_t              status_reg, status_next;

    logic                 out_valid_reg, out_valid_next;
    logic signed [VW-1:0] out_popped_reg, out_popped_next;
    logic signed [VW-1:0] out_min_reg, out_min_next;
    logic [CW-1:0]        out_count_reg, out_count_next;
    status_t              out_status_reg, out_status_next;

    logic signed [VW-1:0] value_rd_reg;
    logic signed [VW-1:0] min_rd_reg;

    logic                 vm_we;
    logic [AW-1:0]        vm_waddr;
    logic [AW-1:0]        vm_raddr;
    logic                 mm_we;
    logic [AW-1:0]        mm_waddr;
    logic signed [VW-1:0] mm_wdata;
    logic [AW-1:0]        mm_raddr;

    logic [SW-1:0]        push_sum;
    logic [SW-1:0]        back_sum;
    logic [AW-1:0]        push_slot;
    logic [AW-1:0]        back_slot;
    logic [AW-1:0]        head_inc;
    logic [AW-1:0]        raddr_dec;
    logic [CW-1:0]        checked_plus1;
    logic signed [VW-1:0] push_min;
    logic signed [VW-1:0] reb_min;
    logic signed [VW-1:0] cur_min;

    always_comb
    begin
        push_sum      = SW'(head_reg) + SW'(count_reg);
        back_sum      = push_sum - SW'(1);
        push_slot     = (push_sum >= DEPTH_S) ? AW'(push_sum - DEPTH_S) : AW'(push_sum);
        back_slot     = (back_sum >= DEPTH_S) ? AW'(back_sum - DEPTH_S) : AW'(back_sum);
        head_inc      = (head_reg == LAST_SLOT) ? '0 : head_reg + AW'(1);
        raddr_dec     = (raddr_reg == '0) ? LAST_SLOT : raddr_reg - AW'(1);
        checked_plus1 = CW'(checked_reg) + CW'(1);
        push_min      = (count_reg != '0 && count_reg != checked_plus1)
                      ? smin(value_reg, back_min_reg) : value_reg;
        reb_min       = first_reg ? value_rd_reg : smin(value_rd_reg, run_min_reg);
        if (count_reg == '0)
        begin
            cur_min = '0;
        end
        else if (count_reg > checked_plus1)
        begin
            cur_min = smin(front_min_reg, back_min_reg);
        end
        else
        begin
            cur_min = front_min_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (vm_we)
        begin
            value_mem[vm_waddr] <= value_reg;
        end
        value_rd_reg <= value_mem[vm_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (mm_we)
        begin
            min_mem[mm_waddr] <= mm_wdata;
        end
        min_rd_reg <= min_mem[mm_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            head_reg      <= '0;
            count_reg     <= '0;
            checked_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            checked_reg   <= checked_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        value_reg      <= value_next;
        front_min_reg  <= front_min_next;
        back_min_reg   <= back_min_next;
        run_min_reg    <= run_min_next;
        ridx_reg       <= ridx_next;
        raddr_reg      <= raddr_next;
        first_reg      <= first_next;
        popped_reg     <= popped_next;
        status_reg     <= status_next;
        out_popped_reg <= out_popped_next;
        out_min_reg    <= out_min_next;
        out_count_reg  <= out_count_next;
        out_status_reg <= out_status_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        value_next      = value_reg;
        head_next       = head_reg;
        count_next      = count_reg;
        checked_next    = checked_reg;
        front_min_next  = front_min_reg;
        back_min_next   = back_min_reg;
        run_min_next    = run_min_reg;
        ridx_next       = ridx_reg;
        raddr_next      = raddr_reg;
        first_next      = first_reg;
        popped_next     = popped_reg;
        status_next     = status_reg;
        out_popped_next = out_popped_reg;
        out_min_next    = out_min_reg;
        out_count_next  = out_count_reg;
        out_status_next = out_status_reg;
        out_valid_next  = out_valid_reg && out_stall;

        vm_we    = 1'b0;
        vm_waddr = push_slot;
        vm_raddr = (state_reg == ST_POP_RD) ? head_reg : raddr_reg;
        mm_we    = 1'b0;
        mm_waddr = push_slot;
        mm_wdata = push_min;
        mm_raddr = head_inc;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    op_next     = op_t'(op);
                    value_next  = value;
                    popped_next = '0;
                    status_next = STATUS_OK;
                    state_next  = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = ST_FINISH;
                unique case (op_reg)
                    OP_PUSH:
                    begin
                        if (count_reg == DEPTH_C)
                        begin
                            status_next = STATUS_PUSH_FULL;
                        end
                        else
                        begin
                            vm_we         = 1'b1;
                            mm_we         = 1'b1;
                            count_next    = count_reg + CW'(1);
                            back_min_next = push_min;
                            if (count_reg == '0)
                            begin
                                front_min_next = push_min;
                            end
                        end
                    end
                    OP_POP:
                    begin
                        if (count_reg == '0)
                        begin
                            status_next = STATUS_POP_EMPTY;
                        end
                        else if (checked_reg == '0)
                        begin
                            raddr_next = back_slot;
                            ridx_next  = AW'(count_reg - CW'(1));
                            first_next = 1'b1;
                            state_next = ST_REB_RD;
                        end
                        else
                        begin
                            state_next = ST_POP_RD;
                        end
                    end
                    OP_CLEAR:
                    begin
                        count_next   = '0;
                        head_next    = '0;
                        checked_next = '0;
                    end
                    OP_NONE:
                    begin
                        state_next = ST_FINISH;
                    end
                endcase
            end
            ST_REB_RD:
            begin
                state_next = ST_REB_WR;
            end
            ST_REB_WR:
            begin
                mm_we        = 1'b1;
                mm_waddr     = raddr_reg;
                mm_wdata     = reb_min;
                run_min_next = reb_min;
                first_next   = 1'b0;
                if (first_reg)
                begin
                    back_min_next = reb_min;
                end
                if (ridx_reg == '0)
                begin
                    checked_next = AW'(count_reg - CW'(1));
                    state_next   = ST_POP_RD;
                end
                else
                begin
                    ridx_next  = ridx_reg - AW'(1);
                    raddr_next = raddr_dec;
                    state_next = ST_REB_RD;
                end
            end
            ST_POP_RD:
            begin
                state_next = ST_POP_FIN;
            end
            ST_POP_FIN:
            begin
                popped_next    = value_rd_reg;
                front_min_next = min_rd_reg;
                head_next      = head_inc;
                count_next     = count_reg - CW'(1);
                if (checked_reg != '0)
                begin
                    checked_next = checked_reg - AW'(1);
                end
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next  = 1'b1;
                    out_popped_next = popped_reg;
                    out_min_next    = cur_min;
                    out_count_next  = count_reg;
                    out_status_next = status_reg;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign in_stall     = (state_reg != ST_IDLE);
    assign out_valid    = out_valid_reg;
    assign popped_value = out_popped_reg;
    assign min_value    = out_min_reg;
    assign count        = out_count_reg;
    assign status       = out_status_reg;

    `FWRM_ASSERT_IMP(a_count_range, 1'b1, count_reg <= DEPTH_C, "entry count above depth")
    `FWRM_ASSERT_IMP(a_checked_inside, 1'b1, checked_reg == '0 || CW'(checked_reg) < count_reg,
        "checked index outside the queue")
    `FWRM_ASSERT_NXT(a_accept_exec, in_valid && !in_stall, state_reg == ST_EXEC,
        "accepted item did not start execution")
    `FWRM_ASSERT_IMP(a_pop_nonempty, state_reg == ST_POP_RD, count_reg != '0,
        "pop read on an empty queue")
    `FWRM_ASSERT_IMP(a_result_from_finish, $rose(out_valid_reg), $past(state_reg == ST_FINISH),
        "result appeared outside the finish state")

endmodule
